/* rtl/mmps_pkg.sv */
package mmps_pkg;

    localparam int DIM = 6;
    localparam int SUM_W = 23;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_INNER = 2'd1;

    typedef logic [2:0] elem_t;
    typedef elem_t [DIM-1:0] row_t;
    typedef row_t [DIM-1:0] mat_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic start;
        logic ack;
    } eng_ctl_t;

    // x mod 6 for x < 256, reciprocal multiply
    function automatic elem_t mod6(input logic [7:0] x);
        logic [15:0] q;
        logic [7:0] r;
        q = 16'(x) * 16'd171;
        r = x - 8'(q[15:10] * 6'd6);
        return r[2:0];
    endfunction

endpackage

/* rtl/modular_matrix_power_sum.sv */
// Channel  | Ports                                          | Direction
// input    | s_valid s_ready s_cmd s_row_index s_col_index s_value | in
// result   | m_valid m_ready m_total_sum                    | out
// config   | cfg_we cfg_index cfg_data                      | in
// A word is accepted whenever the engine is idle: not while a compute runs or its sum waits.
// Compute: M = B*A mod 6, raised to the power n*n-1 by square and multiply;
// the sum adds every entry of A*P*B mod 6, P being that power.
// Reset is synchronous, active low; memories hold garbage until written.
// A finished sum waits in the output register while loads continue.
module modular_matrix_power_sum import mmps_pkg::*; #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_INNER = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [9:0]  s_row_index,
    input  logic [9:0]  s_col_index,
    input  logic [2:0]  s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [22:0] m_total_sum
);

    localparam int NW = $clog2(MAX_ROWS + 1);
    localparam int AW = $clog2(MAX_ROWS * MAX_INNER);
    localparam int DEPTH = MAX_ROWS * MAX_INNER;

    logic [10:0] rows_reg;
    elem_t inner_reg;
    logic [NW-1:0] rows_n;
    elem_t inner_k;
    logic accept, a_we, b_we, busy, done, out_free;
    logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
    elem_t a_rdata, b_rdata;
    eng_ctl_t ctl;
    sum_t sum;
    logic m_valid_reg;
    sum_t m_sum_reg;

    assign s_ready = !busy;
    assign accept = s_valid && s_ready;
    assign a_we = accept && s_cmd == CMD_LOAD_A && 32'(s_row_index) < MAX_ROWS
        && 32'(s_col_index) < MAX_INNER;
    assign b_we = accept && s_cmd == CMD_LOAD_B && 32'(s_row_index) < MAX_INNER
        && 32'(s_col_index) < MAX_ROWS;
    assign a_waddr = AW'(s_row_index) * AW'(MAX_INNER) + AW'(s_col_index);
    assign b_waddr = AW'(s_row_index) * AW'(MAX_ROWS) + AW'(s_col_index);

    always_comb begin
        if (rows_reg == '0) begin
            rows_n = NW'(1);
        end else if (32'(rows_reg) > MAX_ROWS) begin
            rows_n = NW'(MAX_ROWS);
        end else begin
            rows_n = NW'(rows_reg);
        end
        if (inner_reg == '0) begin
            inner_k = 3'd1;
        end else if (32'(inner_reg) > MAX_INNER) begin
            inner_k = 3'(MAX_INNER);
        end else begin
            inner_k = inner_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign ctl.start = accept && s_cmd == CMD_COMPUTE;
    assign ctl.ack = done && out_free;

    mmps_ram #(.DEPTH(DEPTH), .WIDTH(3)) u_a_ram (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(s_value),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    mmps_ram #(.DEPTH(DEPTH), .WIDTH(3)) u_b_ram (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(s_value),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    mmps_engine #(.MAX_ROWS(MAX_ROWS), .MAX_INNER(MAX_INNER)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .rows_n(rows_n),
        .inner_k(inner_k), .a_raddr(a_raddr), .b_raddr(b_raddr),
        .a_rdata(a_rdata), .b_rdata(b_rdata), .busy(busy), .done(done),
        .sum(sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 11'd1;
            inner_reg <= 3'd1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_ROWS) begin
                rows_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_INNER) begin
                inner_reg <= cfg_data[2:0];
            end
            if (ctl.ack) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (ctl.ack) begin
            m_sum_reg <= sum;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_total_sum = m_sum_reg;

endmodule

/* rtl/mmps_ram.sv */
module mmps_ram #(
    parameter int DEPTH = 6144,
    parameter int WIDTH = 3
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mmps_engine.sv */
module mmps_engine import mmps_pkg::*; #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_INNER = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  eng_ctl_t                              ctl,
    input  logic [$clog2(MAX_ROWS+1)-1:0]         rows_n,
    input  elem_t                                 inner_k,
    output logic [$clog2(MAX_ROWS*MAX_INNER)-1:0] a_raddr,
    output logic [$clog2(MAX_ROWS*MAX_INNER)-1:0] b_raddr,
    input  elem_t                                 a_rdata,
    input  elem_t                                 b_rdata,
    output logic                                  busy,
    output logic                                  done,
    output sum_t                                  sum
);

    localparam int NW = $clog2(MAX_ROWS + 1);
    localparam int AW = $clog2(MAX_ROWS * MAX_INNER);
    localparam int EW = 2 * NW;
    localparam logic [AW-1:0] ROWS_A = AW'(MAX_ROWS);
    localparam logic [AW-1:0] INNER_A = AW'(MAX_INNER);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_BASE    = 12'b000000000010,
        S_BDRAIN  = 12'b000000000100,
        S_EXP     = 12'b000000001000,
        S_MUL     = 12'b000000010000,
        S_MCOPY   = 12'b000000100000,
        S_AROW    = 12'b000001000000,
        S_ADRAIN  = 12'b000010000000,
        S_RPROD   = 12'b000100000000,
        S_BCOL    = 12'b001000000000,
        S_BCDRAIN = 12'b010000000000,
        S_FIN     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    elem_t k_reg, k_next;
    logic [NW-1:0] bi_reg, bi_next, bj_reg, bj_next, bt_reg, bt_next;
    elem_t si_reg, si_next, sj_reg, sj_next, st_reg, st_next, rt_reg, rt_next;
    elem_t acc_reg, acc_next;
    mat_t base_reg, base_next, pow_reg, pow_next, tmp_reg, tmp_next;
    row_t ar_reg, ar_next, rp_reg, rp_next;
    logic [EW-1:0] e_reg, e_next;
    logic sq_reg, sq_next;
    logic rv_reg;
    sum_t sum_reg, sum_next;

    logic [NW-1:0] n_last;
    elem_t k_last, mul_entry, prod_term;
    logic [7:0] dot;
    row_t x_row, rp_calc;
    logic [7:0] rp_sum [DIM];

    assign n_last = n_reg - NW'(1);
    assign k_last = k_reg - 3'd1;
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FIN);
    assign sum = sum_reg;

    always_comb begin
        a_raddr = AW'(bt_reg) * INNER_A + AW'(sj_reg);
        b_raddr = AW'(si_reg) * ROWS_A + AW'(bt_reg);
        case (state_reg)
            S_AROW: begin
                a_raddr = AW'(bi_reg) * INNER_A + AW'(st_reg);
            end
            S_BCOL: begin
                b_raddr = AW'(st_reg) * ROWS_A + AW'(bj_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        x_row = sq_reg ? base_reg[si_reg] : pow_reg[si_reg];
        dot = '0;
        for (int t = 0; t < DIM; t++) begin
            dot = dot + 8'(x_row[t] * base_reg[t][sj_reg]);
        end
        mul_entry = mod6(dot);
        for (int j = 0; j < DIM; j++) begin
            rp_sum[j] = '0;
            for (int t = 0; t < DIM; t++) begin
                rp_sum[j] = rp_sum[j] + 8'(ar_reg[t] * pow_reg[t][j]);
            end
            rp_calc[j] = mod6(rp_sum[j]);
        end
        if (state_reg == S_BCOL || state_reg == S_BCDRAIN) begin
            prod_term = mod6(8'(rp_reg[rt_reg] * b_rdata));
        end else begin
            prod_term = mod6(8'(a_rdata * b_rdata));
        end
    end

    always_comb begin
        state_next = state_reg;
        n_next = n_reg;
        k_next = k_reg;
        bi_next = bi_reg;
        bj_next = bj_reg;
        bt_next = bt_reg;
        si_next = si_reg;
        sj_next = sj_reg;
        st_next = st_reg;
        rt_next = st_reg;
        acc_next = acc_reg;
        base_next = base_reg;
        pow_next = pow_reg;
        tmp_next = tmp_reg;
        ar_next = ar_reg;
        rp_next = rp_reg;
        e_next = e_reg;
        sq_next = sq_reg;
        sum_next = sum_reg;
        if (rv_reg) begin
            acc_next = mod6(8'(acc_reg) + 8'(prod_term));
        end
        case (state_reg)
            S_IDLE: begin
                if (ctl.start) begin
                    n_next = rows_n;
                    k_next = inner_k;
                    base_next = '0;
                    tmp_next = '0;
                    ar_next = '0;
                    si_next = '0;
                    sj_next = '0;
                    bt_next = '0;
                    acc_next = '0;
                    state_next = S_BASE;
                end
            end
            S_BASE: begin
                if (bt_reg == n_last) begin
                    bt_next = '0;
                    state_next = S_BDRAIN;
                end else begin
                    bt_next = bt_reg + NW'(1);
                end
            end
            S_BDRAIN: begin
                base_next[si_reg][sj_reg] = acc_next;
                acc_next = '0;
                state_next = S_BASE;
                if (sj_reg == k_last) begin
                    sj_next = '0;
                    if (si_reg == k_last) begin
                        si_next = '0;
                        pow_next = '0;
                        for (int t = 0; t < DIM; t++) begin
                            if (3'(t) < k_reg) begin
                                pow_next[t][t] = 3'd1;
                            end
                        end
                        e_next = EW'(n_reg) * EW'(n_reg) - EW'(1);
                        state_next = S_EXP;
                    end else begin
                        si_next = si_reg + 3'd1;
                    end
                end else begin
                    sj_next = sj_reg + 3'd1;
                end
            end
            S_EXP: begin
                si_next = '0;
                sj_next = '0;
                if (e_reg == '0) begin
                    bi_next = '0;
                    st_next = '0;
                    state_next = S_AROW;
                end else begin
                    sq_next = !e_reg[0];
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                tmp_next[si_reg][sj_reg] = mul_entry;
                if (sj_reg == k_last) begin
                    sj_next = '0;
                    if (si_reg == k_last) begin
                        si_next = '0;
                        state_next = S_MCOPY;
                    end else begin
                        si_next = si_reg + 3'd1;
                    end
                end else begin
                    sj_next = sj_reg + 3'd1;
                end
            end
            S_MCOPY: begin
                if (sq_reg) begin
                    base_next = tmp_reg;
                    e_next = e_reg >> 1;
                    state_next = S_EXP;
                end else begin
                    pow_next = tmp_reg;
                    sq_next = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_AROW: begin
                if (rv_reg) begin
                    ar_next[rt_reg] = a_rdata;
                end
                if (st_reg == k_last) begin
                    state_next = S_ADRAIN;
                end else begin
                    st_next = st_reg + 3'd1;
                end
            end
            S_ADRAIN: begin
                ar_next[rt_reg] = a_rdata;
                state_next = S_RPROD;
            end
            S_RPROD: begin
                rp_next = rp_calc;
                bj_next = '0;
                st_next = '0;
                acc_next = '0;
                state_next = S_BCOL;
            end
            S_BCOL: begin
                if (st_reg == k_last) begin
                    state_next = S_BCDRAIN;
                end else begin
                    st_next = st_reg + 3'd1;
                end
            end
            S_BCDRAIN: begin
                sum_next = sum_reg + SUM_W'(acc_next);
                acc_next = '0;
                st_next = '0;
                state_next = S_BCOL;
                if (bj_reg == n_last) begin
                    bj_next = '0;
                    if (bi_reg == n_last) begin
                        state_next = S_FIN;
                    end else begin
                        bi_next = bi_reg + NW'(1);
                        state_next = S_AROW;
                    end
                end else begin
                    bj_next = bj_reg + NW'(1);
                end
            end
            S_FIN: begin
                if (ctl.ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_IDLE && ctl.start) begin
            sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg <= (state_reg == S_BASE) || (state_reg == S_AROW)
                || (state_reg == S_BCOL);
        end
        n_reg <= n_next;
        k_reg <= k_next;
        bi_reg <= bi_next;
        bj_reg <= bj_next;
        bt_reg <= bt_next;
        si_reg <= si_next;
        sj_reg <= sj_next;
        st_reg <= st_next;
        rt_reg <= rt_next;
        acc_reg <= acc_next;
        base_reg <= base_next;
        pow_reg <= pow_next;
        tmp_reg <= tmp_next;
        ar_reg <= ar_next;
        rp_reg <= rp_next;
        e_reg <= e_next;
        sq_reg <= sq_next;
        sum_reg <= sum_next;
    end

endmodule

/* rtl/mmps_checker.sv */
module mmps_checker import mmps_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_cmd,
    input logic        m_valid,
    input logic        m_ready,
    input logic [22:0] m_total_sum
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_sum))
        else $error("result word dropped or changed while stalled");

    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_COMPUTE |=> !s_ready)
        else $error("input still ready after compute word");

    a_result_from_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word appeared without a running compute");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind modular_matrix_power_sum mmps_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_cmd(s_cmd), .m_valid(m_valid), .m_ready(m_ready),
    .m_total_sum(m_total_sum)
);
